@@ src/sccf_pkg.sv @@
// ----------------------------------------------------------------------------
// sccf_pkg: shared types for the cycle member flagger
// Beat payloads, controller states and the command/status groups that join
// the controller to the search datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sccf_pkg;

  typedef logic [5:0] node_t;
  typedef logic [6:0] count_t;

  typedef struct packed {
    node_t edge_source;
    node_t edge_target;
    logic  edge_present;
    logic  last_item;
  } edge_item_t;

  typedef struct packed {
    node_t node_id;
    logic  in_cycle;
    logic  last_node;
  } flag_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_CMP,
    ST_POP,
    ST_RET,
    ST_RET1,
    ST_RET2,
    ST_EMIT,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic load;
    logic job_init;
    logic start_inc;
    logic visit_start;
    logic push;
    logic step;
    logic cmp;
    logic close;
    logic pop;
    logic ret;
    logic ret1;
    logic ret2;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic start_done;
    logic start_visited;
    logic found;
    logic v_visited;
    logic v_onstk;
    logic root;
    logic pop_last;
    logic depth_one;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ src/sccf_ctrl.sv @@
// ----------------------------------------------------------------------------
// sccf_ctrl: search sequencer
// Steps through edge loading, the depth-first component search, result
// emission and the closing clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sccf_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              edge_valid,
  input  wire              last_item,
  input  sccf_pkg::status_t status,
  output logic             edge_stall,
  output sccf_pkg::cmd_t   cmd
);

  sccf_pkg::state_t state;
  sccf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sccf_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sccf_pkg::ST_LOAD: begin
        if (edge_valid && last_item) state_next = sccf_pkg::ST_START;
      end
      sccf_pkg::ST_START: begin
        if (status.start_done) begin
          state_next = status.n_zero ? sccf_pkg::ST_CLEAR : sccf_pkg::ST_EMIT;
        end else if (!status.start_visited) begin
          state_next = sccf_pkg::ST_SCAN;
        end
      end
      sccf_pkg::ST_SCAN: begin
        if (status.found) begin
          if (status.v_visited && status.v_onstk) state_next = sccf_pkg::ST_CMP;
        end else begin
          state_next = status.root ? sccf_pkg::ST_POP : sccf_pkg::ST_RET;
        end
      end
      sccf_pkg::ST_CMP:  state_next = sccf_pkg::ST_SCAN;
      sccf_pkg::ST_POP: begin
        if (status.pop_last) state_next = sccf_pkg::ST_RET;
      end
      sccf_pkg::ST_RET: begin
        state_next = status.depth_one ? sccf_pkg::ST_START : sccf_pkg::ST_RET1;
      end
      sccf_pkg::ST_RET1: state_next = sccf_pkg::ST_RET2;
      sccf_pkg::ST_RET2: state_next = sccf_pkg::ST_SCAN;
      sccf_pkg::ST_EMIT: begin
        if (status.out_free && status.emit_last) state_next = sccf_pkg::ST_CLEAR;
      end
      sccf_pkg::ST_CLEAR: state_next = sccf_pkg::ST_LOAD;
      default: state_next = sccf_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd        = '0;
    edge_stall = 1'b1;
    case (state)
      sccf_pkg::ST_LOAD: begin
        edge_stall   = 1'b0;
        cmd.load     = edge_valid;
        cmd.job_init = 1'b1;
      end
      sccf_pkg::ST_START: begin
        cmd.start_inc   = !status.start_done && status.start_visited;
        cmd.visit_start = !status.start_done && !status.start_visited;
      end
      sccf_pkg::ST_SCAN: begin
        cmd.step  = status.found;
        cmd.push  = status.found && !status.v_visited;
        cmd.close = !status.found && status.root;
      end
      sccf_pkg::ST_CMP:   cmd.cmp = 1'b1;
      sccf_pkg::ST_POP:   cmd.pop = 1'b1;
      sccf_pkg::ST_RET: begin
        cmd.ret       = 1'b1;
        cmd.start_inc = status.depth_one;
      end
      sccf_pkg::ST_RET1:  cmd.ret1 = 1'b1;
      sccf_pkg::ST_RET2:  cmd.ret2 = 1'b1;
      sccf_pkg::ST_EMIT:  cmd.emit = status.out_free;
      sccf_pkg::ST_CLEAR: cmd.clear = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/sccf_dp.sv @@
// ----------------------------------------------------------------------------
// sccf_dp: graph stores and search datapath
// Adjacency memory, visit/low-link memories, call and component stacks,
// top-frame registers, next-edge finder and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sccf_dp #(
  parameter int MAX_NODES = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  sccf_pkg::count_t     cfg_data,
  input  sccf_pkg::edge_item_t edge_item,
  input  sccf_pkg::cmd_t       cmd,
  input  wire                  flag_stall,
  output sccf_pkg::status_t    status,
  output logic                 flag_valid,
  output sccf_pkg::flag_item_t flag_item
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int FRM_W = IDX_W + CNT_W;
  localparam logic [MAX_NODES-1:0] ROW_ONE = MAX_NODES'(1);

  // memories
  logic [MAX_NODES-1:0] adj  [MAX_NODES];
  logic [IDX_W-1:0]     vnum [MAX_NODES];
  logic [IDX_W-1:0]     low  [MAX_NODES];
  logic [FRM_W-1:0]     frm  [MAX_NODES];
  logic [IDX_W-1:0]     cst  [MAX_NODES];

  logic [MAX_NODES-1:0] adj_rd;
  logic                 adj_rv;
  logic [IDX_W-1:0]     vnum_rd;
  logic [IDX_W-1:0]     low_rd;
  logic [FRM_W-1:0]     frm_rd;
  logic [IDX_W-1:0]     cst_rd;

  sccf_pkg::count_t     nodes_cfg;
  logic [CNT_W-1:0]     ncnt;
  logic [MAX_NODES-1:0] row_vld;
  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] onstk;
  logic [MAX_NODES-1:0] cyc;
  logic [CNT_W-1:0]     depth;
  logic [CNT_W-1:0]     depth_next;
  logic [CNT_W-1:0]     cdepth;
  logic [CNT_W-1:0]     cdepth_next;
  logic [CNT_W-1:0]     nvis;
  logic [CNT_W-1:0]     start;
  logic [IDX_W-1:0]     idx;

  // top frame
  logic [IDX_W-1:0]     u;
  logic [IDX_W-1:0]     u_next;
  logic [CNT_W-1:0]     nxt;
  logic [IDX_W-1:0]     lowu;
  logic [IDX_W-1:0]     vnu;
  logic                 cflag;

  logic [MAX_NODES-1:0] row;
  logic [MAX_NODES-1:0] cand;
  logic [IDX_W-1:0]     vsel;
  logic [CNT_W-1:0]     v_plus;
  logic [IDX_W-1:0]     vt;
  logic                 visit;
  logic [IDX_W-1:0]     srci;
  logic [IDX_W-1:0]     dsti;
  logic                 edge_ok;
  logic [IDX_W-1:0]     frm_node;
  logic [CNT_W-1:0]     frm_nxt;
  logic [CNT_W-1:0]     depth_dec;
  logic [CNT_W-1:0]     frm_ra;
  logic [CNT_W-1:0]     cst_ra;
  logic [IDX_W-1:0]     vnum_ra;
  logic                 mark;
  logic                 emit_last;

  always_comb begin
    ncnt = (nodes_cfg > sccf_pkg::count_t'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                       : CNT_W'(nodes_cfg);
  end

  assign srci    = edge_item.edge_source[IDX_W-1:0];
  assign dsti    = edge_item.edge_target[IDX_W-1:0];
  assign edge_ok = cmd.load && edge_item.edge_present
                && (sccf_pkg::count_t'(edge_item.edge_source) < sccf_pkg::count_t'(ncnt))
                && (sccf_pkg::count_t'(edge_item.edge_target) < sccf_pkg::count_t'(ncnt));

  // next out-edge of the top node at or after nxt, below n
  assign row = adj_rv ? adj_rd : '0;
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      cand[i] = row[i] && (CNT_W'(i) >= nxt) && (CNT_W'(i) < ncnt);
    end
    vsel = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (cand[i]) vsel = IDX_W'(i);
    end
  end
  assign v_plus = CNT_W'(vsel) + CNT_W'(1);

  assign visit    = cmd.visit_start || cmd.push;
  assign vt       = cmd.visit_start ? start[IDX_W-1:0] : vsel;
  assign frm_node = frm_rd[FRM_W-1:CNT_W];
  assign frm_nxt  = frm_rd[CNT_W-1:0];
  assign mark     = cflag || (cst_rd != u);
  assign emit_last = (CNT_W'(idx) + CNT_W'(1)) == ncnt;

  always_comb begin
    u_next = u;
    if (visit) u_next = vt;
    else if (cmd.ret1) u_next = frm_node;

    depth_next = depth;
    if (cmd.clear) depth_next = '0;
    else if (visit) depth_next = depth + CNT_W'(1);
    else if (cmd.ret) depth_next = depth - CNT_W'(1);

    cdepth_next = cdepth;
    if (cmd.clear) cdepth_next = '0;
    else if (visit) cdepth_next = cdepth + CNT_W'(1);
    else if (cmd.pop) cdepth_next = cdepth - CNT_W'(1);
  end

  assign depth_dec = depth - CNT_W'(1);
  assign frm_ra    = depth_next - CNT_W'(1);
  assign cst_ra    = cdepth_next - CNT_W'(1);
  assign vnum_ra   = cmd.ret1 ? frm_node : vsel;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_cfg  <= '0;
      row_vld    <= '0;
      visited    <= '0;
      onstk      <= '0;
      cyc        <= '0;
      depth      <= '0;
      cdepth     <= '0;
      nvis       <= '0;
      start      <= '0;
      idx        <= '0;
      flag_valid <= 1'b0;
    end else begin
      if (cfg_we) nodes_cfg <= cfg_data;
      depth  <= depth_next;
      cdepth <= cdepth_next;
      if (cmd.clear) begin
        row_vld <= '0;
        visited <= '0;
        onstk   <= '0;
        cyc     <= '0;
        nvis    <= '0;
      end else begin
        if (edge_ok) row_vld[srci] <= 1'b1;
        if (visit) begin
          visited[vt] <= 1'b1;
          onstk[vt]   <= 1'b1;
          nvis        <= nvis + CNT_W'(1);
        end
        if (cmd.pop) begin
          onstk[cst_rd] <= 1'b0;
          if (mark) cyc[cst_rd] <= 1'b1;
        end
      end
      if (cmd.job_init) begin
        start <= '0;
        idx   <= '0;
      end else begin
        if (cmd.start_inc) start <= start + CNT_W'(1);
        if (cmd.emit) idx <= idx + IDX_W'(1);
      end
      if (cmd.emit) flag_valid <= 1'b1;
      else if (!flag_stall) flag_valid <= 1'b0;
    end
  end

  // top frame and result payload
  always_ff @(posedge clk) begin
    u <= u_next;
    if (visit) nxt <= '0;
    else if (cmd.step) nxt <= v_plus;
    else if (cmd.ret1) nxt <= frm_nxt;

    if (visit) begin
      lowu <= nvis[IDX_W-1:0];
      vnu  <= nvis[IDX_W-1:0];
    end else if (cmd.cmp) begin
      if (vnum_rd < lowu) lowu <= vnum_rd;
    end else if (cmd.ret2) begin
      if (low_rd < lowu) lowu <= low_rd;
      vnu <= vnum_rd;
    end

    if (cmd.close) cflag <= row[u];
    else if (cmd.pop) cflag <= mark;

    if (cmd.emit) begin
      flag_item.node_id   <= sccf_pkg::node_t'(idx);
      flag_item.in_cycle  <= cyc[idx];
      flag_item.last_node <= emit_last;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (edge_ok) begin
      if (row_vld[srci]) adj[srci][dsti] <= 1'b1;
      else adj[srci] <= ROW_ONE << dsti;
    end
    adj_rd <= adj[u_next];
    adj_rv <= row_vld[u_next];

    if (visit) begin
      vnum[vt]                <= nvis[IDX_W-1:0];
      cst[cdepth[IDX_W-1:0]]  <= vt;
    end
    if (cmd.push) begin
      frm[depth_dec[IDX_W-1:0]] <= {u, v_plus};
      low[u]                    <= lowu;
    end
    vnum_rd <= vnum[vnum_ra];
    low_rd  <= low[frm_node];
    frm_rd  <= frm[frm_ra[IDX_W-1:0]];
    cst_rd  <= cst[cst_ra[IDX_W-1:0]];
  end

  always_comb begin
    status.n_zero        = ncnt == '0;
    status.start_done    = start >= ncnt;
    status.start_visited = visited[start[IDX_W-1:0]];
    status.found         = |cand;
    status.v_visited     = visited[vsel];
    status.v_onstk       = onstk[vsel];
    status.root          = lowu == vnu;
    status.pop_last      = cst_rd == u;
    status.depth_one     = depth == CNT_W'(1);
    status.emit_last     = emit_last;
    status.out_free      = !flag_valid || !flag_stall;
  end

endmodule

`default_nettype wire

@@ src/scc_cycle_member_flagger_core.sv @@
// ----------------------------------------------------------------------------
// scc_cycle_member_flagger_core: flags graph nodes that lie on a cycle
// Loads directed edges into an adjacency matrix, runs an iterative
// strongly-connected-component search and reports one flag per node.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | beat
//  edge    | in  | edge_valid/stall    | edge_item: source, target, present, last
//  flag    | out | flag_valid/stall    | flag_item: node_id, in_cycle, last_node
//  cfg     | in  | cfg_valid/ready     | cfg_data: node total (7 bits)
//
//  Edge beats load back to back while edge_stall is low. The last beat
//  starts the search: each start node in turn, each edge examined (plus
//  a compare step when its target is still on the component stack) and
//  the pop and return steps per node visited, paced by the registered
//  stack reads; then n flag beats and a clear before edges load again.
//  Reset (rst, synchronous) empties all stores and sets the node total to zero.
//  A stalled flag beat holds; edge_stall is high after the last beat until
//  the clear cycle ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scc_cycle_member_flagger_core #(
  parameter int MAX_NODES = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  edge_valid,
  output logic                 edge_stall,
  input  sccf_pkg::edge_item_t edge_item,
  output logic                 flag_valid,
  input  wire                  flag_stall,
  output sccf_pkg::flag_item_t flag_item,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  sccf_pkg::count_t     cfg_data
);

  sccf_pkg::cmd_t    cmd;
  sccf_pkg::status_t status;

  // the node total register takes a write in any cycle
  assign cfg_ready = 1'b1;

  sccf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .edge_valid (edge_valid),
    .last_item  (edge_item.last_item),
    .status     (status),
    .edge_stall (edge_stall),
    .cmd        (cmd)
  );

  sccf_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .edge_item  (edge_item),
    .cmd        (cmd),
    .flag_stall (flag_stall),
    .status     (status),
    .flag_valid (flag_valid),
    .flag_item  (flag_item)
  );

  // the closing beat, once accepted, is followed by a locked edge channel
  a_last_locks: assert property (@(posedge clk) disable iff (rst)
    edge_valid && !edge_stall && edge_item.last_item |=> edge_stall)
    else $error("edge channel open right after closing beat");

  // no edge loading while results are being produced
  a_emit_locked: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> edge_stall)
    else $error("emission while edge channel open");

  // a stalled flag beat holds its payload
  a_flag_hold: assert property (@(posedge clk) disable iff (rst)
    flag_valid && flag_stall |=> flag_valid && $stable(flag_item))
    else $error("stalled flag beat changed");

endmodule

`default_nettype wire
